// ===== hw/rtl/srr_pkg.sv =====
// ----------------------------------------------------------------------------
// srr_pkg
// Shared codes and constants for the selective-repeat receiver.
// ----------------------------------------------------------------------------
`default_nettype none
package srr_pkg;
	typedef enum logic [2:0] {
		OP_SYN   = 3'd0,
		OP_ACK   = 3'd1,
		OP_META  = 3'd2,
		OP_DATA  = 3'd3,
		OP_FIN   = 3'd4,
		OP_RESET = 3'd5,
		OP_TICK  = 3'd6,
		OP_OTHER = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		KIND_ACK     = 3'd0,
		KIND_FINACK  = 3'd1,
		KIND_SYNACK  = 3'd2,
		KIND_DELIVER = 3'd3,
		KIND_CLOSED  = 3'd4
	} kind_t;

	localparam logic [16:0] META_HEADER_LEN = 17'd10;
	localparam logic [31:0] DEFAULT_ISN     = 32'd12345;
	localparam logic [5:0]  RESET_WINDOW    = 6'd32;
endpackage
`default_nettype wire

// ===== hw/rtl/selective_repeat_receiver.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_receiver
// Receiver side of a selective-repeat transfer with a SACK bitmap.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; results leave one per
// cycle on strobe and cannot be stalled, last marks the final one of a request.
// A handled request answers from the execute state when it answers nothing or
// only SYN-ACK or close, and passes through the ack state for an ACK-only answer;
// META, DATA or FIN first pass the slot store read and the release loop, which
// frees one slot per cycle, before the ack. No clearing pass is needed after
// reset.
`default_nettype none
module selective_repeat_receiver #(
	parameter int WINDOW_SLOTS = 32,
	parameter int SACK_BITS    = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  operation,
	input  wire logic [31:0] seq,
	input  wire logic [31:0] ack_num,
	input  wire logic [10:0] payload_len,
	input  wire logic [15:0] payload_handle,
	input  wire logic [63:0] meta_size,
	input  wire logic [15:0] meta_name_bytes,
	input  wire logic [31:0] src_addr,
	input  wire logic [15:0] src_port,
	input  wire logic [31:0] local_isn,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [5:0]  cfg_data,
	output logic             strobe,
	output logic [2:0]       kind,
	output logic [31:0]      seq_out,
	output logic [31:0]      ack_out,
	output logic [5:0]       window_adv,
	output logic [31:0]      sack_bits,
	output logic [15:0]      deliver_handle,
	output logic [10:0]      deliver_len,
	output logic             last
);
	import srr_pkg::*;

	localparam int IDX_W = $clog2(WINDOW_SLOTS);
	localparam int CNT_W = $clog2(WINDOW_SLOTS + 1);
	localparam int SB    = (SACK_BITS < 32) ? SACK_BITS : 32;
	localparam logic [IDX_W:0] SLOTS = (IDX_W + 1)'(WINDOW_SLOTS);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EXEC = 5'b00010,
		ST_RDH  = 5'b00100,
		ST_REL  = 5'b01000,
		ST_ACK  = 5'b10000
	} state_t;

	state_t state_q;

	// request registers
	op_t         op_q;
	logic [31:0] seq_q, ackn_q, saddr_q, isn_q;
	logic [10:0] plen_q;
	logic [15:0] handle_q, nlen_q, sport_q;
	logic [63:0] fsize_q;

	// protocol state
	logic [5:0]       recv_q;
	logic             hs_q, closed_q, fin_seen_q;
	logic [31:0]      ne_q, fin_seq_q, offered_q, client_ip_q;
	logic [15:0]      client_port_q;
	logic [63:0]      stored_file_size_q;
	logic [WINDOW_SLOTS-1:0] valid_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] head_q;

	// slot store: handle and length
	logic [26:0] mem [WINDOW_SLOTS];
	logic [26:0] rd_q;

	logic [6:0]       used;
	logic [31:0]      seq_gap;
	logic [IDX_W:0]   slot_sum;
	logic [IDX_W-1:0] slot_idx, head_nx;
	logic             in_window, fin_done, foreign;
	logic [7:0]       adv_full;
	logic [31:0]      sack_c;

	// next result
	logic        res_strobe, res_last;
	kind_t       res_kind;
	logic [31:0] res_seq, res_ack, res_sack;
	logic [5:0]  res_win;
	logic [15:0] res_handle;
	logic [10:0] res_len;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	always_comb begin
		used = ({1'b0, recv_q} > 7'(WINDOW_SLOTS)) ? 7'(WINDOW_SLOTS) : {1'b0, recv_q};
		seq_gap = seq_q - ne_q;
		in_window = (seq_gap < 32'(used));
		slot_sum = {1'b0, head_q} + {1'b0, seq_gap[IDX_W-1:0]};
		if (slot_sum >= SLOTS) begin
			slot_sum = slot_sum - SLOTS;
		end
		slot_idx = slot_sum[IDX_W-1:0];
		head_nx = (head_q == IDX_W'(WINDOW_SLOTS - 1)) ? '0 : head_q + 1'b1;
		fin_done = fin_seen_q && (ne_q == fin_seq_q + 32'd1);
		foreign = (saddr_q != client_ip_q) || (sport_q != client_port_q);
		adv_full = (8'(count_q) >= 8'(used)) ? 8'd0 : 8'(used) - 8'(count_q);
	end

	always_comb begin
		logic [IDX_W:0] s;
		sack_c = '0;
		for (int i = 0; i < SB; i++) begin
			if (i + 1 < WINDOW_SLOTS) begin
				s = {1'b0, head_q} + (IDX_W + 1)'(i + 1);
				if (s >= SLOTS) begin
					s = s - SLOTS;
				end
				sack_c[i] = valid_q[s[IDX_W-1:0]];
			end
		end
	end

	always_comb begin
		res_strobe = 1'b0;
		res_kind   = KIND_ACK;
		res_seq    = '0;
		res_ack    = '0;
		res_win    = '0;
		res_sack   = '0;
		res_handle = '0;
		res_len    = '0;
		res_last   = 1'b0;
		unique case (state_q)
			ST_EXEC: begin
				if (!closed_q && !hs_q && op_q == OP_SYN) begin
					res_strobe = 1'b1;
					res_kind   = KIND_SYNACK;
					res_seq    = isn_q;
					res_ack    = seq_q + 32'd1;
					res_win    = used[5:0];
					res_last   = 1'b1;
				end else if (!closed_q && hs_q && op_q == OP_RESET && !foreign) begin
					res_strobe = 1'b1;
					res_kind   = KIND_CLOSED;
					res_last   = 1'b1;
				end
			end
			ST_REL: begin
				if (valid_q[head_q]) begin
					res_strobe = 1'b1;
					res_kind   = KIND_DELIVER;
					res_seq    = ne_q;
					res_handle = rd_q[26:11];
					res_len    = rd_q[10:0];
				end
			end
			ST_ACK: begin
				res_strobe = 1'b1;
				res_kind   = fin_done ? KIND_FINACK : KIND_ACK;
				res_ack    = ne_q;
				res_win    = adv_full[5:0];
				res_sack   = sack_c;
				res_last   = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC && hs_q && !closed_q && !foreign && op_q == OP_DATA &&
				in_window && !valid_q[slot_idx]) begin
			mem[slot_idx] <= {handle_q, plen_q};
		end
		if (state_q == ST_RDH) begin
			rd_q <= mem[head_q];
		end else if (state_q == ST_REL) begin
			rd_q <= mem[head_nx];
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q     <= op_t'(operation);
			seq_q    <= seq;
			ackn_q   <= ack_num;
			plen_q   <= payload_len;
			handle_q <= payload_handle;
			fsize_q  <= meta_size;
			nlen_q   <= meta_name_bytes;
			saddr_q  <= src_addr;
			sport_q  <= src_port;
			isn_q    <= local_isn;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= ST_IDLE;
			recv_q             <= RESET_WINDOW;
			hs_q               <= 1'b0;
			closed_q           <= 1'b0;
			fin_seen_q         <= 1'b0;
			ne_q               <= 32'd1;
			fin_seq_q          <= '0;
			offered_q          <= DEFAULT_ISN;
			client_ip_q        <= '0;
			client_port_q      <= '0;
			stored_file_size_q <= '0;
			valid_q            <= '0;
			count_q            <= '0;
			head_q             <= '0;
			strobe             <= 1'b0;
			kind               <= KIND_ACK;
			seq_out            <= '0;
			ack_out            <= '0;
			window_adv         <= '0;
			sack_bits          <= '0;
			deliver_handle     <= '0;
			deliver_len        <= '0;
			last               <= 1'b0;
		end else begin
			strobe         <= res_strobe;
			kind           <= res_kind;
			seq_out        <= res_seq;
			ack_out        <= res_ack;
			window_adv     <= res_win;
			sack_bits      <= res_sack;
			deliver_handle <= res_handle;
			deliver_len    <= res_len;
			last           <= res_last;
			if (cfg_valid) begin
				recv_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					priority if (closed_q) begin
						state_q <= ST_IDLE;
					end else if (!hs_q) begin
						state_q <= ST_IDLE;
						if (op_q == OP_SYN) begin
							client_ip_q   <= saddr_q;
							client_port_q <= sport_q;
							offered_q     <= isn_q;
						end else if (op_q == OP_ACK && ackn_q == offered_q + 32'd1) begin
							hs_q <= 1'b1;
						end
					end else if (op_q == OP_TICK) begin
						state_q <= ST_ACK;
					end else if (foreign) begin
						state_q <= ST_IDLE;
					end else if (op_q == OP_RESET) begin
						state_q  <= ST_IDLE;
						closed_q <= 1'b1;
					end else begin
						if (op_q == OP_META || op_q == OP_DATA || op_q == OP_FIN) begin
							state_q <= ST_RDH;
						end else begin
							state_q <= ST_ACK;
						end
						// advance the head for in-order META or FIN
						if ((op_q == OP_META && seq_q == ne_q && {6'd0, plen_q} >= META_HEADER_LEN &&
								{6'd0, plen_q} == META_HEADER_LEN + {1'b0, nlen_q}) ||
								(op_q == OP_FIN && seq_q == ne_q)) begin
							if (valid_q[head_q]) begin
								valid_q[head_q] <= 1'b0;
								count_q <= count_q - 1'b1;
							end
							head_q <= head_nx;
							ne_q   <= ne_q + 32'd1;
						end
						if (op_q == OP_META && seq_q == ne_q &&
								{6'd0, plen_q} >= META_HEADER_LEN) begin
							stored_file_size_q <= fsize_q;
						end
						if (op_q == OP_DATA && in_window && !valid_q[slot_idx]) begin
							valid_q[slot_idx] <= 1'b1;
							count_q <= count_q + 1'b1;
						end
						if (op_q == OP_FIN) begin
							fin_seen_q <= 1'b1;
							fin_seq_q  <= seq_q;
						end
					end
				end
				ST_RDH: begin
					state_q <= ST_REL;
				end
				ST_REL: begin
					if (valid_q[head_q]) begin
						valid_q[head_q] <= 1'b0;
						count_q        <= count_q - 1'b1;
						head_q         <= head_nx;
						ne_q           <= ne_q + 32'd1;
					end else begin
						state_q <= ST_ACK;
					end
				end
				ST_ACK: begin
					state_q <= ST_IDLE;
					if (op_q != OP_TICK && fin_done) begin
						closed_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) == 32'($countones(valid_q)))
		else $error("buffered count disagrees with valid bits");

	a_deliver_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind == KIND_DELIVER |-> !last)
		else $error("delivery marked last");

	a_ack_follows_release: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_REL && !valid_q[head_q] |=> state_q == ST_ACK)
		else $error("release loop did not end in ack");

	a_synack_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (kind == KIND_SYNACK || kind == KIND_CLOSED) |-> last)
		else $error("single result not marked last");
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for selective_repeat_receiver. A table of directed requests
// covers the handshake, the window edges and each packet kind, then random
// traffic runs under several receive windows and idle rates. Every request
// is run through an in-bench receiver model; its answers, or the fixed answer
// of a table row, are checked in order against the strobed results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import srr_pkg::*;

	localparam logic [31:0] CL_IP   = 32'hC0A8_0107;
	localparam logic [15:0] CL_PORT = 16'hD431;
	localparam int          STALL_LIMIT = 3000;

	typedef struct {
		op_t         op;
		logic [31:0] seq;
		logic [31:0] ackn;
		logic [10:0] plen;
		logic [15:0] hnd;
		logic [63:0] fsize;
		logic [15:0] nlen;
		logic [31:0] addr;
		logic [15:0] port;
		logic [31:0] isn;
	} pkt_t;

	typedef struct {
		kind_t       kind;
		logic [31:0] seq_o;
		logic [31:0] ack_o;
		logic [5:0]  win;
		logic [31:0] sack;
		logic [15:0] hnd;
		logic [10:0] len;
		logic        lst;
	} ans_t;

	typedef struct {
		pkt_t pkt;
		int   n_exp;
		ans_t exp;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  operation = '0;
	logic [31:0] seq = '0;
	logic [31:0] ack_num = '0;
	logic [10:0] payload_len = '0;
	logic [15:0] payload_handle = '0;
	logic [63:0] meta_size = '0;
	logic [15:0] meta_name_bytes = '0;
	logic [31:0] src_addr = '0;
	logic [15:0] src_port = '0;
	logic [31:0] local_isn = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [5:0]  cfg_data = '0;
	logic        strobe;
	logic [2:0]  kind;
	logic [31:0] seq_out;
	logic [31:0] ack_out;
	logic [5:0]  window_adv;
	logic [31:0] sack_bits;
	logic [15:0] deliver_handle;
	logic [10:0] deliver_len;
	logic        last;

	selective_repeat_receiver dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .seq(seq), .ack_num(ack_num),
		.payload_len(payload_len), .payload_handle(payload_handle),
		.meta_size(meta_size), .meta_name_bytes(meta_name_bytes), .src_addr(src_addr),
		.src_port(src_port), .local_isn(local_isn),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.strobe(strobe), .kind(kind), .seq_out(seq_out), .ack_out(ack_out),
		.window_adv(window_adv), .sack_bits(sack_bits),
		.deliver_handle(deliver_handle), .deliver_len(deliver_len), .last(last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver model state
	logic        rx_hs, rx_closed, rx_fin_seen;
	logic [31:0] rx_next, rx_fin_seq, rx_isn, rx_ip;
	logic [15:0] rx_port;
	logic [31:0] rx_valid;
	logic [15:0] rx_hnd [32];
	logic [10:0] rx_len [32];
	int          rx_count, rx_head;
	logic [5:0]  rx_win;

	ans_t step_q[$];
	ans_t pending_answers[$];
	row_t rows[$];
	int   mismatches = 0;
	int   stall_cycles = 0;
	int   gap_pct = 0;

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic int used_window();
		return (rx_win > 6'd32) ? 32 : int'(rx_win);
	endfunction

	task automatic add_answer(input kind_t k, input logic [31:0] s, input logic [31:0] a,
			input logic [5:0] w, input logic [31:0] sk, input logic [15:0] h,
			input logic [10:0] l);
		ans_t x;
		x = '{k, s, a, w, sk, h, l, 1'b0};
		step_q.push_back(x);
	endtask

	task automatic advance_next();
		if (rx_valid[rx_head]) begin
			rx_valid[rx_head] = 1'b0;
			rx_count--;
		end
		rx_head = (rx_head + 1) % 32;
		rx_next = rx_next + 32'd1;
	endtask

	function automatic logic fin_done();
		return rx_fin_seen && rx_next == rx_fin_seq + 32'd1;
	endfunction

	// compute the answers one request draws and update the receiver state
	task automatic predict_answers(input pkt_t p);
		logic [31:0] d, sk;
		int          w, adv;
		step_q.delete();
		if (rx_closed) begin
		end else if (!rx_hs) begin
			if (p.op == OP_SYN) begin
				rx_ip = p.addr;
				rx_port = p.port;
				rx_isn = p.isn;
				add_answer(KIND_SYNACK, p.isn, p.seq + 32'd1, 6'(used_window()), '0, '0, '0);
			end else if (p.op == OP_ACK && p.ackn == rx_isn + 32'd1) begin
				rx_hs = 1'b1;
			end
		end else if (p.op == OP_TICK || (p.addr == rx_ip && p.port == rx_port)) begin
			if (p.op == OP_RESET) begin
				rx_closed = 1'b1;
				add_answer(KIND_CLOSED, '0, '0, '0, '0, '0, '0);
			end else begin
				case (p.op)
					OP_META: begin
						if (p.seq == rx_next && p.plen >= 11'd10 &&
								int'(p.plen) == 10 + int'(p.nlen))
							advance_next();
					end
					OP_DATA: begin
						d = p.seq - rx_next;
						if (d < 32'(used_window())) begin
							w = (rx_head + int'(d)) % 32;
							if (!rx_valid[w]) begin
								rx_valid[w] = 1'b1;
								rx_hnd[w] = p.hnd;
								rx_len[w] = p.plen;
								rx_count++;
							end
						end
					end
					OP_FIN: begin
						rx_fin_seen = 1'b1;
						rx_fin_seq = p.seq;
						if (p.seq == rx_next)
							advance_next();
					end
					default: ;
				endcase
				if (p.op == OP_META || p.op == OP_DATA || p.op == OP_FIN) begin
					while (rx_valid[rx_head]) begin
						add_answer(KIND_DELIVER, rx_next, '0, '0, '0,
							rx_hnd[rx_head], rx_len[rx_head]);
						advance_next();
					end
				end
				w = used_window();
				adv = (rx_count >= w) ? 0 : w - rx_count;
				sk = '0;
				for (int i = 0; i < 31; i++)
					sk[i] = rx_valid[(rx_head + i + 1) % 32];
				add_answer(fin_done() ? KIND_FINACK : KIND_ACK, '0, rx_next, 6'(adv),
					sk, '0, '0);
				if (p.op != OP_TICK && fin_done())
					rx_closed = 1'b1;
			end
		end
		if (step_q.size() > 0)
			step_q[step_q.size() - 1].lst = 1'b1;
	endtask

	// drive one request and hold it until taken
	task automatic send_request(input pkt_t p, input int n_exp, input ans_t exp);
		while ($urandom_range(99) < gap_pct) begin
			@(negedge clk);
			start = 1'b0;
		end
		@(negedge clk);
		operation = p.op;
		seq = p.seq;
		ack_num = p.ackn;
		payload_len = p.plen;
		payload_handle = p.hnd;
		meta_size = p.fsize;
		meta_name_bytes = p.nlen;
		src_addr = p.addr;
		src_port = p.port;
		local_isn = p.isn;
		start = 1'b1;
		do @(posedge clk); while (busy);
		predict_answers(p);
		if (n_exp < 0)
			foreach (step_q[i]) pending_answers.push_back(step_q[i]);
		else if (n_exp > 0)
			pending_answers.push_back(exp);
		// drop start so the same request is not taken twice
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_answers.size() > 0) @(posedge clk);
		@(negedge clk);
		start = 1'b0;
		repeat (6) @(posedge clk);
	endtask

	task automatic write_window(input logic [5:0] w);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = w;
		do @(posedge clk); while (!cfg_ready);
		rx_win = w;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic add_row(input op_t op, input logic [31:0] s, input logic [31:0] a,
			input logic [10:0] pl, input logic [15:0] h, input logic [63:0] fs,
			input logic [15:0] nl, input logic [31:0] ad, input logic [15:0] pt,
			input logic [31:0] isn, input int n_exp);
		row_t r;
		r.pkt = '{op, s, a, pl, h, fs, nl, ad, pt, isn};
		r.n_exp = n_exp;
		r.exp = '{KIND_ACK, '0, '0, '0, '0, '0, '0, 1'b1};
		rows.push_back(r);
	endtask

	function automatic pkt_t random_request();
		pkt_t p;
		int   r;
		p = '{op_t'($urandom_range(7)), $urandom(), $urandom(), 11'($urandom_range(1500)),
			16'($urandom()), {$urandom(), $urandom()}, 16'($urandom()),
			rx_ip, rx_port, $urandom()};
		r = $urandom_range(99);
		if (r < 50) begin
			p.op = OP_DATA;
			if ($urandom_range(19) != 0)
				p.seq = rx_next + 32'($urandom_range(40));
		end else if (r < 62) begin
			p.op = OP_META;
			p.seq = ($urandom_range(4) != 0) ? rx_next : rx_next + 32'd1;
			if ($urandom_range(3) != 0) begin
				p.nlen = 16'($urandom_range(60));
				p.plen = ($urandom_range(3) != 0) ? 11'(p.nlen + 16'd10)
					: 11'($urandom_range(20));
			end
		end else if (r < 72) begin
			p.op = OP_TICK;
		end else if (r < 80) begin
			// foreign source, any operation
			case ($urandom_range(2))
				0: p.addr = rx_ip ^ ($urandom() | 32'd1);
				1: p.port = rx_port ^ 16'($urandom() | 1);
				default: begin
					p.addr = ~rx_ip;
					p.port = ~rx_port;
				end
			endcase
		end else if (r < 86) begin
			case ($urandom_range(2))
				0: p.op = OP_ACK;
				1: p.op = OP_SYN;
				default: p.op = OP_OTHER;
			endcase
		end else if (r < 92) begin
			// fin far ahead, never reached in this run
			p.op = OP_FIN;
			p.seq = rx_next + 32'h4000_0000 + 32'($urandom_range(32'h3FFF_FFFF));
		end else begin
			p.op = OP_DATA;
			p.seq = rx_next - 32'($urandom_range(1, 40));
		end
		return p;
	endfunction

	task automatic check_field(input string f, input logic [63:0] g, input logic [63:0] e);
		if (g !== e)
			report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", f, g, e));
	endtask

	always @(posedge clk) begin
		ans_t e;
		if (arst_n && strobe) begin
			if (pending_answers.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0d", kind));
			end else begin
				e = pending_answers.pop_front();
				check_field("kind", 64'(kind), 64'(e.kind));
				check_field("seq_out", 64'(seq_out), 64'(e.seq_o));
				check_field("ack_out", 64'(ack_out), 64'(e.ack_o));
				check_field("window_adv", 64'(window_adv), 64'(e.win));
				check_field("sack_bits", 64'(sack_bits), 64'(e.sack));
				check_field("deliver_handle", 64'(deliver_handle), 64'(e.hnd));
				check_field("deliver_len", 64'(deliver_len), 64'(e.len));
				check_field("last", 64'(last), 64'(e.lst));
			end
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL selective_repeat_receiver");
			$finish;
		end
	end

	initial begin
		ans_t        none;
		pkt_t        p;
		logic [5:0]  phase_win [5];
		int          phase_gap [5];
		none = '{KIND_ACK, '0, '0, '0, '0, '0, '0, 1'b1};
		phase_win = '{6'd1, 6'd0, 6'd63, 6'd32, 6'($urandom_range(2, 31))};
		phase_gap = '{0, 63, 0, 27, 63};

		rx_hs = 0; rx_closed = 0; rx_fin_seen = 0;
		rx_next = 32'd1; rx_fin_seq = '0; rx_isn = DEFAULT_ISN;
		rx_ip = '0; rx_port = '0; rx_valid = '0;
		rx_count = 0; rx_head = 0; rx_win = RESET_WINDOW;

		// before the handshake
		add_row(OP_TICK, 32'd5, '0, '0, '0, '0, '0, CL_IP, CL_PORT, '0, 0);
		add_row(OP_DATA, 32'd1, '0, 11'd100, 16'h1, '0, '0, CL_IP, CL_PORT, '0, 0);
		add_row(OP_SYN, '1, '0, '0, '0, '0, '0, '1, '1, '0, 1);
		rows[$].exp = '{KIND_SYNACK, '0, '0, 6'd32, '0, '0, '0, 1'b1};
		add_row(OP_SYN, '0, '0, '0, '0, '0, '0, CL_IP, CL_PORT, '1, 1);
		rows[$].exp = '{KIND_SYNACK, '1, 32'd1, 6'd32, '0, '0, '0, 1'b1};
		add_row(OP_ACK, '0, 32'd12346, '0, '0, '0, '0, CL_IP, CL_PORT, '0, 0);
		add_row(OP_ACK, '0, '0, '0, '0, '0, '0, CL_IP, CL_PORT, '0, 0);
		// connected
		add_row(OP_DATA, 32'd1, '0, 11'd7, 16'h7, '0, '0, CL_IP, ~CL_PORT, '0, 0);
		add_row(OP_TICK, '0, '0, '0, '0, '0, '0, 32'h0, 16'h0, '0, 1);
		rows[$].exp = '{KIND_ACK, '0, 32'd1, 6'd32, '0, '0, '0, 1'b1};
		add_row(OP_DATA, 32'd3, '0, 11'd1500, 16'hFFFF, '0, '0, CL_IP, CL_PORT, '0, -1);
		add_row(OP_DATA, 32'd3, '0, 11'd9, 16'h1234, '0, '0, CL_IP, CL_PORT, '0, -1);
		add_row(OP_META, 32'd1, '0, 11'd5, '0, 64'd77, '0, CL_IP, CL_PORT, '0, -1);
		add_row(OP_META, 32'd1, '0, 11'd12, '0, 64'd99, 16'd5, CL_IP, CL_PORT, '0, -1);
		add_row(OP_META, 32'd1, '0, 11'd10, '0, '1, 16'd0, CL_IP, CL_PORT, '0, -1);
		add_row(OP_DATA, 32'd2, '0, 11'd0, 16'h0, '0, '0, CL_IP, CL_PORT, '0, -1);
		add_row(OP_DATA, 32'd36, '0, 11'd50, 16'h5555, '0, '0, CL_IP, CL_PORT, '0, -1);
		add_row(OP_DATA, 32'd35, '0, 11'd1024, 16'hAAAA, '0, '0, CL_IP, CL_PORT, '0, -1);
		add_row(OP_DATA, '1, '0, 11'd1, 16'h1, '0, '0, CL_IP, CL_PORT, '0, -1);
		add_row(OP_OTHER, '0, '0, '0, '0, '0, '0, CL_IP, CL_PORT, '0, -1);
		add_row(OP_SYN, 32'd8, '0, '0, '0, '0, '0, CL_IP, CL_PORT, 32'd9, -1);
		add_row(OP_ACK, '0, '1, '0, '0, '0, '0, CL_IP, CL_PORT, '0, -1);
		add_row(OP_RESET, '0, '0, '0, '0, '0, '0, ~CL_IP, CL_PORT, '0, 0);
		add_row(OP_TICK, '0, '0, '0, '0, '0, '0, ~CL_IP, ~CL_PORT, '0, -1);
		add_row(OP_FIN, 32'h8000_0000, '0, '0, '0, '0, '0, CL_IP, CL_PORT, '0, -1);
		add_row(OP_TICK, '0, '0, '0, '0, '0, '0, CL_IP, CL_PORT, '0, -1);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_window(6'd32);
		foreach (rows[i])
			send_request(rows[i].pkt, rows[i].n_exp, rows[i].exp);

		for (int ph = 0; ph < 5; ph++) begin
			wait_idle();
			write_window(phase_win[ph]);
			gap_pct = phase_gap[ph];
			repeat (40)
				send_request(random_request(), -1, none);
		end

		// close by an in-order fin or by a reset from the client
		wait_idle();
		p = random_request();
		p.addr = rx_ip;
		p.port = rx_port;
		p.op = $urandom_range(1) ? OP_FIN : OP_RESET;
		p.seq = rx_next;
		send_request(p, -1, none);
		repeat (3)
			send_request(random_request(), -1, none);
		@(negedge clk);
		start = 1'b0;

		while (pending_answers.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("PASS selective_repeat_receiver");
		else
			$display("FAIL selective_repeat_receiver");
		$finish;
	end
endmodule
`default_nettype wire
